### design/itio_pkg.sv
// Shared constants, codes and item types for the interrupt/timer/I/O interface.
package itio_pkg;

  localparam int unsigned TIMER_BITS  = 14;
  localparam int unsigned ENABLE_BITS = 15;
  localparam int unsigned PIN_BITS    = 16;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_LINES = 2'd2,
    OP_TICK  = 2'd3
  } op_e;

  // serial bit numbers
  localparam logic [4:0] BIT_MODE     = 5'd0;
  localparam logic [4:0] BIT_PEND_CLR = 5'd3;
  localparam logic [4:0] BIT_LAST_LOW = 5'd14;
  localparam logic [4:0] BIT_EN_HIGH  = 5'd15;

  // read byte numbers
  localparam logic [1:0] BYTE_LOW  = 2'd0;
  localparam logic [1:0] BYTE_HIGH = 2'd1;
  localparam logic [1:0] BYTE_PINS = 2'd2;
  localparam logic [1:0] BYTE_NONE = 2'd3;

  typedef struct packed {
    op_e        mode;
    logic [4:0] bit_index;
    logic       bit_value;
    logic [1:0] byte_index;
    logic [7:0] key_row;
    logic       alpha_key;
    logic [1:0] int_levels;
  } in_item_t;

  typedef struct packed {
    logic [7:0]          read_data;
    logic                irq;
    logic [PIN_BITS-1:0] pin_outputs;
    logic                in_timer_mode;
  } out_item_t;

endpackage

### design/itio_if.sv
// Valid/ready channel interfaces for input items and result items.
interface itio_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [4:0] bit_index;
  logic       bit_value;
  logic [1:0] byte_index;
  logic [7:0] key_row;
  logic       alpha_key;
  logic [1:0] int_levels;

  modport source (output valid, mode, bit_index, bit_value, byte_index, key_row, alpha_key,
                  int_levels, input ready);
  modport sink (input valid, mode, bit_index, bit_value, byte_index, key_row, alpha_key,
                int_levels, output ready);
endinterface

interface itio_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        irq;
  logic [15:0] pin_outputs;
  logic        in_timer_mode;

  modport source (output valid, read_data, irq, pin_outputs, in_timer_mode, input ready);
  modport sink (input valid, read_data, irq, pin_outputs, in_timer_mode, output ready);
endinterface

### design/itio_exec.sv
// Interface state registers and the single-pass update for one item.
module itio_exec (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  itio_pkg::in_item_t  item_i,
  output itio_pkg::out_item_t result_o
);
  import itio_pkg::*;

  logic                   mode_q, mode_d;
  logic [ENABLE_BITS-1:0] enable_q, enable_d;
  logic [1:0]             ext_q, ext_d;
  logic                   pending_q, pending_d;
  logic [TIMER_BITS-1:0]  interval_q, interval_d;
  logic                   changed_q, changed_d;
  logic [TIMER_BITS-1:0]  loaded_q, loaded_d;
  logic [TIMER_BITS-1:0]  down_q, down_d;
  logic [TIMER_BITS-1:0]  latched_q, latched_d;
  logic [PIN_BITS-1:0]    pin_q, pin_d;
  logic                   irq_q, irq_d;

  logic                   reload;
  logic                   leave;
  logic                   irq_eval;
  logic [4:0]             bit_off;
  logic [TIMER_BITS-1:0]  dec;
  logic [15:0]            lat_w;
  logic [ENABLE_BITS-1:0] active;
  logic [7:0]             data;
  logic                   alpha;

  assign lat_w = 16'(latched_q);
  assign alpha = pin_q[5];
  assign bit_off = item_i.bit_index - 5'd1;
  assign dec = down_q - TIMER_BITS'(1);

  always_comb begin
    mode_d     = mode_q;
    enable_d   = enable_q;
    ext_d      = ext_q;
    pending_d  = pending_q;
    interval_d = interval_q;
    changed_d  = changed_q;
    loaded_d   = loaded_q;
    down_d     = down_q;
    latched_d  = latched_q;
    pin_d      = pin_q;
    reload     = 1'b0;
    leave      = 1'b0;
    irq_eval   = 1'b0;
    data       = '0;

    unique case (item_i.mode)
      OP_WRITE: begin
        if (item_i.bit_index == BIT_MODE) begin
          if (mode_q != item_i.bit_value) begin
            mode_d = item_i.bit_value;
            if (item_i.bit_value) begin
              latched_d = (loaded_q != '0) ? down_q : '0;
              changed_d = 1'b0;
            end else if (changed_q) begin
              reload = 1'b1;
            end
          end
        end else if (item_i.bit_index <= BIT_LAST_LOW) begin
          if (mode_q) begin
            for (int k = 0; k < TIMER_BITS; k++) begin
              if (bit_off[3:0] == 4'(k)) interval_d[k] = item_i.bit_value;
            end
            changed_d = 1'b1;
          end else begin
            enable_d[bit_off[3:0]] = item_i.bit_value;
            if (item_i.bit_index == BIT_PEND_CLR) pending_d = 1'b0;
            irq_eval = 1'b1;
          end
        end else if (item_i.bit_index == BIT_EN_HIGH) begin
          if (!mode_q) begin
            enable_d[ENABLE_BITS-1] = item_i.bit_value;
            irq_eval = 1'b1;
          end
        end else begin
          leave = 1'b1;
          pin_d[item_i.bit_index[3:0]] = item_i.bit_value;
        end
      end
      OP_READ: begin
        unique case (item_i.byte_index)
          BYTE_LOW: begin
            if (mode_q) begin
              data = {lat_w[6:0], 1'b1};
            end else begin
              data = {item_i.key_row[4:0], !ext_q[1], !ext_q[0], 1'b0};
              if (!alpha && item_i.alpha_key) data[3] = 1'b0;
            end
          end
          BYTE_HIGH: begin
            if (mode_q) data = {!irq_q, lat_w[13:7]};
            else        data = {5'b0, item_i.key_row[7:5]};
          end
          BYTE_PINS: begin
            leave = 1'b1;
            data  = {2'b0, !alpha, pin_q[4:2], 2'b0};
          end
          BYTE_NONE: begin
            leave = 1'b1;
          end
          default: ;
        endcase
      end
      OP_LINES: begin
        ext_d    = item_i.int_levels;
        irq_eval = 1'b1;
      end
      OP_TICK: begin
        if (loaded_q != '0) begin
          if (dec == '0) begin
            down_d    = loaded_q;
            pending_d = 1'b1;
            irq_eval  = 1'b1;
          end else begin
            down_d = dec;
          end
        end
      end
      default: ;
    endcase

    if (leave && mode_q) begin
      mode_d = 1'b0;
      if (changed_q) reload = 1'b1;
    end
    if (reload) begin
      loaded_d = interval_d;
      down_d   = interval_d;
    end

    // line 3 follows the timer flag only while an interval is programmed
    active    = '0;
    active[1:0] = ext_d;
    active[2] = (interval_d != '0) && pending_d;
    irq_d     = irq_eval ? |(active & enable_d) : irq_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      enable_q   <= '0;
      ext_q      <= '0;
      pending_q  <= 1'b0;
      interval_q <= '0;
      changed_q  <= 1'b0;
      loaded_q   <= '0;
      down_q     <= '0;
      latched_q  <= '0;
      pin_q      <= '0;
      irq_q      <= 1'b0;
    end else if (fire_i) begin
      mode_q     <= mode_d;
      enable_q   <= enable_d;
      ext_q      <= ext_d;
      pending_q  <= pending_d;
      interval_q <= interval_d;
      changed_q  <= changed_d;
      loaded_q   <= loaded_d;
      down_q     <= down_d;
      latched_q  <= latched_d;
      pin_q      <= pin_d;
      irq_q      <= irq_d;
    end
  end

  assign result_o.read_data     = data;
  assign result_o.irq           = irq_d;
  assign result_o.pin_outputs   = pin_d;
  assign result_o.in_timer_mode = mode_d;

endmodule

### design/interrupt_timer_io_interface_core.sv
// Top level: input register, single-pass update and result register.
// One item is taken per clock cycle with no bubbles while the output is not stalled: an
// accepted beat lands in the input register, is applied to the interface state
// when it advances, and its result is registered in the output register. The input
// side keeps accepting while the output register holds a result that is not yet
// taken, as long as the input register is empty; a stalled output backs up
// through the input register one beat deep.
module interrupt_timer_io_interface_core (
  input logic clk_i,
  input logic rst_ni,
  itio_in_if.sink    in_i,
  itio_out_if.source out_o
);
  import itio_pkg::*;

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  out_item_t result;
  logic      advance;
  logic      in_fire;

  assign advance  = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_fire  = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire)      in_valid_q <= 1'b1;
      else if (advance) in_valid_q <= 1'b0;
      if (advance)          out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_item_q.mode       <= op_e'(in_i.mode);
      in_item_q.bit_index  <= in_i.bit_index;
      in_item_q.bit_value  <= in_i.bit_value;
      in_item_q.byte_index <= in_i.byte_index;
      in_item_q.key_row    <= in_i.key_row;
      in_item_q.alpha_key  <= in_i.alpha_key;
      in_item_q.int_levels <= in_i.int_levels;
    end
    if (advance) out_item_q <= result;
  end

  itio_exec u_exec (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (in_item_q),
    .result_o (result)
  );

  assign out_o.valid         = out_valid_q;
  assign out_o.read_data     = out_item_q.read_data;
  assign out_o.irq           = out_item_q.irq;
  assign out_o.pin_outputs   = out_item_q.pin_outputs;
  assign out_o.in_timer_mode = out_item_q.in_timer_mode;

endmodule

### design/itio_chk.sv
// Port-level checker for the interface core, bound to the top level.
module itio_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  read_data_i,
  input logic        irq_i,
  input logic [15:0] pin_outputs_i,
  input logic        in_timer_mode_i
);

  // an empty output register never holds off the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input not ready while output register empty");

  // a fresh result comes from an accepted input beat
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result beat without matching input beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(read_data_i) && $stable(irq_i) && $stable(pin_outputs_i) &&
      $stable(in_timer_mode_i))
    else $error("stalled result changed");

endmodule

bind interrupt_timer_io_interface_core itio_chk u_itio_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .read_data_i     (out_o.read_data),
  .irq_i           (out_o.irq),
  .pin_outputs_i   (out_o.pin_outputs),
  .in_timer_mode_i (out_o.in_timer_mode)
);
